>>> sv/per_track_sliding_window_vote_unit_assert.svh
// assertion macros for the per-track vote unit
// included by the top level; needs clk_i and rst_ni in the including scope
`ifndef PER_TRACK_SLIDING_WINDOW_VOTE_UNIT_ASSERT_SVH
`define PER_TRACK_SLIDING_WINDOW_VOTE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PTSW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ptsw assertion failed");
`define PTSW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ptsw assertion failed");
`else
`define PTSW_ASSERT(lbl, prop)
`define PTSW_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> sv/ptsw_pkg.sv
// constants, register map and age table of the per-track vote unit
// no dependencies
`timescale 1ns / 1ps
package ptsw_pkg;

  localparam int unsigned TRACKS_DEF     = 16;
  localparam int unsigned WINDOW_MAX_DEF = 32;

  localparam logic [2:0] MODE_RST   = 3'd0;
  localparam logic [5:0] WLEN_RST   = 6'd25;
  localparam logic [5:0] POS_TH_RST = 6'd16;
  localparam logic [5:0] NEG_TH_RST = 6'd16;

  localparam logic [2:0] MODE_VEHICLE  = 3'd0;
  localparam logic [2:0] MODE_PLATE    = 3'd1;
  localparam logic [2:0] MODE_AGE      = 3'd2;
  localparam logic [2:0] MODE_LIVENESS = 3'd4;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WLEN   = 2'd1;
  localparam logic [1:0] REG_POS_TH = 2'd2;
  localparam logic [1:0] REG_NEG_TH = 2'd3;

  localparam logic       CMD_ERASE  = 1'b1;
  localparam logic [8:0] LABEL_NONE = 9'h1FF;

  localparam logic [6:0] AGE_BOUNDS [16] = '{
    7'd1, 7'd6, 7'd7, 7'd12, 7'd13, 7'd18, 7'd19, 7'd28,
    7'd29, 7'd35, 7'd36, 7'd45, 7'd46, 7'd55, 7'd56, 7'd100
  };

  function automatic logic [6:0] age_lo(input logic [2:0] cls);
    return AGE_BOUNDS[{cls, 1'b0}];
  endfunction

  function automatic logic [6:0] age_hi(input logic [2:0] cls);
    return AGE_BOUNDS[{cls, 1'b1}];
  endfunction

endpackage

>>> sv/per_track_sliding_window_vote_unit.sv
// per-track sliding-window label vote, top level
// depends on ptsw_pkg and per_track_sliding_window_vote_unit_assert.svh
//
// input stream carries one observation or erase item; tdata holds the track id,
// label and score, tuser holds cmd, box_valid and label_valid.  an observation
// gives one result item on the output stream, an erase gives none.  the apb
// port holds mode, window length and the two liveness thresholds.
// one item at a time: the track table is scanned one entry a cycle through
// the metadata memory, then the window of n labels is read from the label
// memory and a shared compare-and-count unit takes one window slot per cycle,
// or the whole window at once in liveness mode.  the result sits in an
// output register, so the next item is taken while it waits; a stalled
// receiver holds the block only when the next result is ready.  reset empties
// the track table and loads register defaults; memories are not cleared,
// entries are written before use.
`timescale 1ns / 1ps
`include "per_track_sliding_window_vote_unit_assert.svh"
module per_track_sliding_window_vote_unit #(
  parameter int unsigned TRACKS     = ptsw_pkg::TRACKS_DEF,
  parameter int unsigned WINDOW_MAX = ptsw_pkg::WINDOW_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // id[30:0], label[39:31], score[55:40]
  input  logic [55:0] s_axis_tdata,
  // cmd[0], box_valid[1], label_valid[2]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // voted_label[8:0], best_score[24:9], age_low[31:25], age_high[38:32],
  // echo_id[69:39], zero pad[71:70]
  output logic [71:0] m_axis_tdata,
  // result_valid[0], table_full[1]
  output logic [1:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptsw_pkg::*;

  localparam int unsigned TW     = $clog2(TRACKS);
  localparam int unsigned HW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned FW     = $clog2(WINDOW_MAX + 1);
  localparam int unsigned LAW    = TW + HW;
  localparam int unsigned LDEPTH = TRACKS << HW;

  typedef struct packed {
    logic [30:0]        track;
    logic [FW-1:0]      fill;
    logic [HW-1:0]      head;
    logic signed [15:0] best;
  } meta_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_HOLDRD, S_HOLDW, S_APPLY, S_LOAD, S_VOTE, S_EMIT
  } state_e;

  function automatic logic [HW-1:0] ptr_inc(input logic [HW-1:0] p);
    return (p == HW'(WINDOW_MAX - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [HW-1:0] ptr_dec(input logic [HW-1:0] p);
    return (p == '0) ? HW'(WINDOW_MAX - 1) : p - 1'b1;
  endfunction

  // configuration
  logic [2:0] mode_q;
  logic [5:0] wlen_q, pos_th_q, neg_th_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RST;
      wlen_q   <= WLEN_RST;
      pos_th_q <= POS_TH_RST;
      neg_th_q <= NEG_TH_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_MODE:   mode_q   <= pwdata[2:0];
        REG_WLEN:   wlen_q   <= pwdata[5:0];
        REG_POS_TH: pos_th_q <= pwdata[5:0];
        REG_NEG_TH: neg_th_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:   prdata = {29'd0, mode_q};
      REG_WLEN:   prdata = {26'd0, wlen_q};
      REG_POS_TH: prdata = {26'd0, pos_th_q};
      REG_NEG_TH: prdata = {26'd0, neg_th_q};
      default:    prdata = '0;
    endcase
  end

  // effective window length
  logic [FW-1:0] eff_len;
  always_comb begin
    if (wlen_q == 6'd0)                     eff_len = FW'(1);
    else if (8'(wlen_q) > 8'(WINDOW_MAX))   eff_len = FW'(WINDOW_MAX);
    else                                    eff_len = FW'(wlen_q);
  end

  // state
  state_e              state_q;
  logic                cmd_q, box_q, lvalid_q;
  logic [30:0]         id_q;
  logic signed [8:0]   value_q, voted_q;
  logic signed [15:0]  score_q, cur_best_q;
  logic [2:0]          md_q;
  logic [TW:0]         scnt_q;
  logic                rd_vld_q, found_q, free_found_q, full_q, has_t_q;
  logic [TW-1:0]       rd_idx_q, t_q, free_q;
  logic [FW-1:0]       cur_fill_q, n_q, lcnt_q, vcnt_q, best_cnt_q;
  logic [HW-1:0]       cur_head_q, ptr_q, ld_idx_q;
  logic                ld_vld_q;
  logic [TRACKS-1:0]   used_q;
  logic signed [8:0]   lbuf_q [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] lmask_q;
  logic                out_vld_q;
  logic [71:0]         out_data_q;
  logic [1:0]          out_user_q;

  // memories
  meta_t             meta_mem [TRACKS];
  logic signed [8:0] lab_mem  [LDEPTH];
  meta_t             meta_rd_q;
  logic signed [8:0] lab_rd_q;
  logic              meta_we, lab_we;
  logic [TW-1:0]     meta_waddr;
  meta_t             meta_wdata;
  logic [LAW-1:0]    lab_waddr, lab_raddr;

  // input decode
  logic              acc;
  logic signed [8:0] in_label;
  logic              in_hold;
  assign acc      = s_axis_tvalid & s_axis_tready;
  assign in_label = s_axis_tdata[39] ? LABEL_NONE : s_axis_tdata[39:31];
  assign s_axis_tready = (state_q == S_IDLE);

  // apply step
  logic          hold, push, do_write, alloc;
  logic [TW-1:0] tsel;
  logic [FW-1:0] base_fill, new_fill, f_sel;
  logic [HW-1:0] base_head, new_head, h_sel;
  logic signed [15:0] new_best;

  assign hold      = (md_q == MODE_VEHICLE) || (md_q == MODE_PLATE) || (md_q == MODE_AGE);
  assign push      = !hold || (value_q != LABEL_NONE);
  assign alloc     = push && !found_q && free_found_q;
  assign do_write  = push && (found_q || free_found_q);
  assign tsel      = found_q ? t_q : free_q;
  assign base_fill = found_q ? cur_fill_q : '0;
  assign base_head = found_q ? cur_head_q : '0;
  assign new_fill  = (base_fill < eff_len) ? base_fill + 1'b1 : eff_len;
  assign new_head  = ptr_inc(base_head);
  assign new_best  = (found_q && !(score_q > cur_best_q)) ? cur_best_q : score_q;
  assign f_sel     = do_write ? new_fill : cur_fill_q;
  assign h_sel     = do_write ? new_head : cur_head_q;

  // shared compare-and-count unit
  logic signed [8:0]     vsel;
  logic [WINDOW_MAX-1:0] match, ones, zeros;
  logic [FW-1:0]         cnt, pos_cnt, neg_cnt;
  always_comb begin
    vsel = lbuf_q[vcnt_q[HW-1:0]];
    for (int j = 0; j < WINDOW_MAX; j++) begin
      match[j] = lmask_q[j] && (lbuf_q[j] == vsel);
      ones[j]  = lmask_q[j] && (lbuf_q[j] == 9'sd1);
      zeros[j] = lmask_q[j] && (lbuf_q[j] == 9'sd0);
    end
    cnt     = FW'($countones(match));
    pos_cnt = FW'($countones(ones));
    neg_cnt = FW'($countones(zeros));
  end

  // memory port control
  always_comb begin
    meta_we     = (state_q == S_APPLY) && do_write;
    lab_we      = meta_we;
    meta_waddr  = tsel;
    meta_wdata  = '{track: id_q, fill: new_fill, head: new_head, best: new_best};
    lab_waddr   = {tsel, base_head};
    if (state_q == S_LOAD) lab_raddr = {t_q, ptr_q};
    else                   lab_raddr = {t_q, ptr_dec(cur_head_q)};
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    meta_rd_q <= meta_mem[scnt_q[TW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (lab_we) lab_mem[lab_waddr] <= value_q;
    lab_rd_q <= lab_mem[lab_raddr];
  end

  // window buffer, loaded from the label memory
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && ld_vld_q) lbuf_q[ld_idx_q] <= lab_rd_q;
  end

  // sequencer
  logic               res_valid;
  logic signed [15:0] res_best;
  logic               age_ok;
  logic               emit_go;
  assign res_valid = box_q && (voted_q != LABEL_NONE);
  assign res_best  = has_t_q ? cur_best_q : 16'sd0;
  assign age_ok    = (md_q == MODE_AGE) && (voted_q[8:3] == 6'd0);
  assign in_hold   = 1'b0;
  assign emit_go   = (state_q == S_EMIT) && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= '0;
      out_vld_q    <= 1'b0;
      rd_vld_q     <= 1'b0;
      ld_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      full_q       <= 1'b0;
      has_t_q      <= 1'b0;
      lmask_q      <= '0;
      scnt_q       <= '0;
      lcnt_q       <= '0;
      vcnt_q       <= '0;
    end else begin
      if (emit_go)            out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            cmd_q        <= s_axis_tuser[0];
            box_q        <= s_axis_tuser[1];
            lvalid_q     <= s_axis_tuser[2];
            id_q         <= s_axis_tdata[30:0];
            md_q         <= (mode_q > MODE_LIVENESS) ? MODE_VEHICLE : mode_q;
            value_q      <= s_axis_tuser[2] ? in_label : LABEL_NONE;
            score_q      <= (s_axis_tuser[2] && (mode_q == MODE_PLATE ||
                             mode_q == MODE_LIVENESS)) ? s_axis_tdata[55:40] : 16'sd0;
            scnt_q       <= '0;
            rd_vld_q     <= 1'b0;
            found_q      <= 1'b0;
            free_found_q <= 1'b0;
            full_q       <= 1'b0;
            has_t_q      <= 1'b0;
            voted_q      <= LABEL_NONE;
            if (s_axis_tuser[0] != CMD_ERASE && !s_axis_tuser[1]) state_q <= S_EMIT;
            else                                                 state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_vld_q) begin
            if (used_q[rd_idx_q] && meta_rd_q.track == id_q && !found_q) begin
              found_q    <= 1'b1;
              t_q        <= rd_idx_q;
              cur_fill_q <= meta_rd_q.fill;
              cur_head_q <= meta_rd_q.head;
              cur_best_q <= meta_rd_q.best;
            end
            if (!used_q[rd_idx_q] && !free_found_q) begin
              free_found_q <= 1'b1;
              free_q       <= rd_idx_q;
            end
          end
          if (scnt_q < (TW + 1)'(TRACKS)) begin
            rd_vld_q <= 1'b1;
            rd_idx_q <= scnt_q[TW-1:0];
            scnt_q   <= scnt_q + 1'b1;
          end else begin
            rd_vld_q <= 1'b0;
            state_q  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (cmd_q == CMD_ERASE) begin
            if (found_q) used_q[t_q] <= 1'b0;
            state_q <= S_IDLE;
          end else if (hold && lvalid_q && value_q == LABEL_NONE && found_q &&
                       cur_fill_q != '0) begin
            state_q <= S_HOLDRD;
          end else begin
            state_q <= S_APPLY;
          end
        end
        S_HOLDRD: state_q <= S_HOLDW;
        S_HOLDW: begin
          // newest label of the track stands in for the unknown one
          value_q <= lab_rd_q;
          state_q <= S_APPLY;
        end
        S_APPLY: begin
          lcnt_q   <= '0;
          ld_vld_q <= 1'b0;
          lmask_q  <= '0;
          n_q      <= (f_sel > eff_len) ? eff_len : f_sel;
          ptr_q    <= ptr_dec(h_sel);
          if (do_write) begin
            if (alloc) used_q[tsel] <= 1'b1;
            t_q        <= tsel;
            cur_fill_q <= new_fill;
            cur_head_q <= new_head;
            cur_best_q <= new_best;
            has_t_q    <= 1'b1;
            state_q    <= S_LOAD;
          end else if (push) begin
            full_q  <= 1'b1;
            state_q <= S_EMIT;
          end else if (found_q) begin
            has_t_q <= 1'b1;
            state_q <= S_LOAD;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_LOAD: begin
          if (ld_vld_q) lmask_q[ld_idx_q] <= 1'b1;
          if (lcnt_q < n_q) begin
            ld_vld_q <= 1'b1;
            ld_idx_q <= lcnt_q[HW-1:0];
            lcnt_q   <= lcnt_q + 1'b1;
            ptr_q    <= ptr_dec(ptr_q);
          end else begin
            ld_vld_q   <= 1'b0;
            vcnt_q     <= '0;
            best_cnt_q <= '0;
            voted_q    <= LABEL_NONE;
            state_q    <= S_VOTE;
          end
        end
        S_VOTE: begin
          if (md_q == MODE_LIVENESS) begin
            if (n_q < eff_len)                     voted_q <= LABEL_NONE;
            else if (8'(pos_cnt) > 8'(pos_th_q))   voted_q <= 9'sd1;
            else if (8'(neg_cnt) > 8'(neg_th_q))   voted_q <= 9'sd0;
            else                                   voted_q <= LABEL_NONE;
            state_q <= S_EMIT;
          end else begin
            // plurality, ties to the smaller label
            if (cnt > best_cnt_q || (cnt == best_cnt_q && vsel < voted_q)) begin
              best_cnt_q <= cnt;
              voted_q    <= vsel;
            end
            vcnt_q <= vcnt_q + 1'b1;
            if (vcnt_q == n_q - 1'b1) state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_user_q <= {full_q, res_valid};
            out_data_q <= {2'b00, id_q,
                           age_ok ? age_hi(voted_q[2:0]) : 7'd0,
                           age_ok ? age_lo(voted_q[2:0]) : 7'd0,
                           res_best, voted_q};
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q & {2{~in_hold}};

  `PTSW_ASSERT(a_fill_bounded, meta_we |-> (meta_wdata.fill != '0 && meta_wdata.fill <= FW'(WINDOW_MAX)))
  `PTSW_ASSERT(a_result_held, (out_vld_q && !m_axis_tready) |=> $stable(m_axis_tdata))
  `PTSW_ASSERT(a_count_bounded, (state_q == S_VOTE) |-> (best_cnt_q <= n_q && cnt <= n_q))
  `PTSW_ASSERT(a_busy_no_accept, (state_q != S_IDLE) |-> !s_axis_tready)

endmodule
